FILE: design/lvc_pkg.sv
// Shared types, constants and the outcode function of the line viewport clipper.
`default_nettype none
package lvc_pkg;

  localparam int COORD_BITS      = 16;
  localparam int MAX_CLIP_ROUNDS = 4;
  localparam int T_FRAC          = 16;
  localparam int DW              = COORD_BITS + 1;
  localparam int TW              = T_FRAC + 1;
  localparam int PW              = DW + TW + 1;
  localparam int SW              = PW - T_FRAC + 1;
  localparam int DIV_STAGES      = 4;
  localparam int DIV_STEP        = T_FRAC / DIV_STAGES;
  localparam int DATA_BITS       = 6 * COORD_BITS;
  localparam int CFG_AW          = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [4:0] code_t;
  typedef logic [2:0][COORD_BITS-1:0] pnt_t;

  localparam code_t OC_NONE   = 5'd0;
  localparam code_t OC_LEFT   = 5'd2;
  localparam code_t OC_RIGHT  = 5'd4;
  localparam code_t OC_BOTTOM = 5'd8;
  localparam code_t OC_TOP    = 5'd16;

  localparam int OC_TOP_BIT    = 4;
  localparam int OC_BOTTOM_BIT = 3;
  localparam int OC_RIGHT_BIT  = 2;

  localparam coord_t COORD_MAX = coord_t'((1 << (COORD_BITS - 1)) - 1);
  localparam coord_t COORD_MIN = coord_t'(-(1 << (COORD_BITS - 1)));

  localparam logic [CFG_AW-1:0] REG_CLIP_ENABLE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MIN_X       = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MAX_X       = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MIN_Y       = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MAX_Y       = 3'd4;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
  } bounds_t;

  typedef struct packed {
    code_t [1:0] code;
    pnt_t  [1:0] p;
  } seg_t;

  function automatic code_t outcode(input coord_t x, input coord_t y, input bounds_t b);
    code_t c;
    c = OC_NONE;
    if ($signed(x) < $signed(b.min_x)) begin
      c = c | OC_LEFT;
    end else if ($signed(x) > $signed(b.max_x)) begin
      c = c | OC_RIGHT;
    end
    if ($signed(y) < $signed(b.min_y)) begin
      c = c | OC_TOP;
    end else if ($signed(y) > $signed(b.max_y)) begin
      c = c | OC_BOTTOM;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/lvc_div_stage.sv
// One registered stage of the restoring divider: DIV_STEP quotient bits per cycle while en is high.
`default_nettype none
module lvc_div_stage (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [lvc_pkg::DW-1:0]       rem_i,
  input  wire logic [lvc_pkg::DW-1:0]       den_i,
  input  wire logic [lvc_pkg::T_FRAC-1:0]   quo_i,
  output logic      [lvc_pkg::DW-1:0]       rem_o,
  output logic      [lvc_pkg::DW-1:0]       den_o,
  output logic      [lvc_pkg::T_FRAC-1:0]   quo_o
);
  import lvc_pkg::*;

  logic [DW-1:0]     rem_c;
  logic [T_FRAC-1:0] quo_c;
  logic [DW:0]       sh_c;

  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     den_r;
  logic [T_FRAC-1:0] quo_r;

  always_comb begin
    rem_c = rem_i;
    quo_c = quo_i;
    sh_c  = '0;
    for (int j = 0; j < DIV_STEP; j++) begin
      sh_c = {rem_c, 1'b0};
      if (sh_c >= {1'b0, den_i}) begin
        sh_c  = sh_c - {1'b0, den_i};
        quo_c = {quo_c[T_FRAC-2:0], 1'b1};
      end else begin
        quo_c = {quo_c[T_FRAC-2:0], 1'b0};
      end
      rem_c = sh_c[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_c;
      den_r <= den_i;
      quo_r <= quo_c;
    end
  end

  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule
`default_nettype wire

FILE: design/lvc_round.sv
// One clip round: edge select, pipelined edge fraction, interpolate and re-code.
`default_nettype none
module lvc_round (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire lvc_pkg::bounds_t bnd,
  input  wire logic             in_v,
  input  wire lvc_pkg::seg_t    in_seg,
  output logic                  out_v,
  output lvc_pkg::seg_t         out_seg
);
  import lvc_pkg::*;

  typedef struct packed {
    seg_t                  seg;
    logic                  active;
    logic                  k;
    logic                  axis;
    coord_t                bound;
    logic [2:0][DW-1:0]    diff;
    logic                  tz;
    logic                  tone;
  } ctx_t;

  // select stage
  ctx_t            ctx0_c;
  logic [DW-1:0]   num_c;
  logic [DW-1:0]   den_c;
  code_t           act_c;
  coord_t          p0a_c;
  coord_t          p1a_c;

  logic            v0_r;
  ctx_t            ctx0_r;
  logic [DW-1:0]   num_r;
  logic [DW-1:0]   den_r;

  always_comb begin
    ctx0_c        = '0;
    ctx0_c.seg    = in_seg;
    ctx0_c.active = (|(in_seg.code[0] | in_seg.code[1])) &&
                    !(|(in_seg.code[0] & in_seg.code[1]));
    ctx0_c.k      = in_seg.code[1] > in_seg.code[0];
    act_c         = ctx0_c.k ? in_seg.code[1] : in_seg.code[0];
    if (act_c[OC_TOP_BIT]) begin
      ctx0_c.axis  = 1'b1;
      ctx0_c.bound = bnd.min_y;
    end else if (act_c[OC_BOTTOM_BIT]) begin
      ctx0_c.axis  = 1'b1;
      ctx0_c.bound = bnd.max_y;
    end else if (act_c[OC_RIGHT_BIT]) begin
      ctx0_c.axis  = 1'b0;
      ctx0_c.bound = bnd.max_x;
    end else begin
      ctx0_c.axis  = 1'b0;
      ctx0_c.bound = bnd.min_x;
    end
    p0a_c = ctx0_c.axis ? coord_t'(in_seg.p[0][1]) : coord_t'(in_seg.p[0][0]);
    p1a_c = ctx0_c.axis ? coord_t'(in_seg.p[1][1]) : coord_t'(in_seg.p[1][0]);
    num_c = DW'($signed(ctx0_c.bound)) - DW'($signed(p0a_c));
    den_c = DW'($signed(p1a_c)) - DW'($signed(p0a_c));
    for (int i = 0; i < 3; i++) begin
      ctx0_c.diff[i] = DW'($signed(in_seg.p[1][i])) - DW'($signed(in_seg.p[0][i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx0_r <= ctx0_c;
      num_r  <= num_c;
      den_r  <= den_c;
    end
  end

  // magnitude stage: zero and full-length fractions are settled here
  ctx_t            ctx1_c;
  logic [DW-1:0]   n_c;
  logic [DW-1:0]   d_c;

  logic            v1_r;
  ctx_t            ctx1_r;
  logic [DW-1:0]   n_r;
  logic [DW-1:0]   d_r;

  always_comb begin
    ctx1_c      = ctx0_r;
    n_c         = num_r[DW-1] ? (~num_r + 1'b1) : num_r;
    d_c         = den_r[DW-1] ? (~den_r + 1'b1) : den_r;
    ctx1_c.tz   = (den_r == '0) || ((num_r[DW-1] != den_r[DW-1]) && (num_r != '0));
    ctx1_c.tone = n_c >= d_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r <= ctx1_c;
      n_r    <= n_c;
      d_r    <= d_c;
    end
  end

  // divider stages
  logic [DW-1:0]     rem_w [DIV_STAGES+1];
  logic [DW-1:0]     den_w [DIV_STAGES+1];
  logic [T_FRAC-1:0] quo_w [DIV_STAGES+1];
  logic              vd_r  [DIV_STAGES];
  ctx_t              ctxd_r[DIV_STAGES];

  assign rem_w[0] = n_r;
  assign den_w[0] = d_r;
  assign quo_w[0] = '0;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    lvc_div_stage u_div (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_w[s]),
      .den_i (den_w[s]),
      .quo_i (quo_w[s]),
      .rem_o (rem_w[s+1]),
      .den_o (den_w[s+1]),
      .quo_o (quo_w[s+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[s] <= 1'b0;
      end else if (en) begin
        vd_r[s] <= (s == 0) ? v1_r : vd_r[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctxd_r[s] <= (s == 0) ? ctx1_r : ctxd_r[(s == 0) ? 0 : s-1];
      end
    end
  end

  // multiply stage
  ctx_t                  ctxm_in;
  logic [TW-1:0]         t_c;
  logic signed [PW-1:0]  prod_c [3];

  logic                  vm_r;
  ctx_t                  ctxm_r;
  logic signed [PW-1:0]  prod_r [3];

  always_comb begin
    ctxm_in = ctxd_r[DIV_STAGES-1];
    if (ctxm_in.tz) begin
      t_c = '0;
    end else if (ctxm_in.tone) begin
      t_c = TW'(1) << T_FRAC;
    end else begin
      t_c = {1'b0, quo_w[DIV_STAGES]};
    end
    for (int i = 0; i < 3; i++) begin
      prod_c[i] = $signed(ctxm_in.diff[i]) * $signed({1'b0, t_c});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= vd_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctxm_r <= ctxm_in;
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= prod_c[i];
      end
    end
  end

  // round, add, saturate and re-code the moved endpoint
  logic signed [PW-1:0]  rnd_c;
  logic signed [SW-1:0]  sum_c;
  pnt_t                  q_c;
  seg_t                  seg_nxt;

  logic                  out_v_r;
  seg_t                  out_seg_r;

  always_comb begin
    q_c   = '0;
    rnd_c = '0;
    sum_c = '0;
    for (int i = 0; i < 3; i++) begin
      rnd_c = prod_r[i] + PW'(1 << (T_FRAC - 1));
      sum_c = SW'($signed(ctxm_r.seg.p[0][i])) + SW'($signed(rnd_c[PW-1:T_FRAC]));
      if (sum_c > SW'(COORD_MAX)) begin
        q_c[i] = COORD_MAX;
      end else if (sum_c < SW'(COORD_MIN)) begin
        q_c[i] = COORD_MIN;
      end else begin
        q_c[i] = sum_c[COORD_BITS-1:0];
      end
    end
    if (ctxm_r.axis) begin
      q_c[1] = ctxm_r.bound;
    end else begin
      q_c[0] = ctxm_r.bound;
    end
    seg_nxt = ctxm_r.seg;
    if (ctxm_r.active) begin
      seg_nxt.p[ctxm_r.k]    = q_c;
      seg_nxt.code[ctxm_r.k] = outcode(coord_t'(q_c[0]), coord_t'(q_c[1]), bnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_seg_r <= seg_nxt;
    end
  end

  assign out_v   = out_v_r;
  assign out_seg = out_seg_r;

endmodule
`default_nettype wire

FILE: design/line_viewport_clipper.sv
// Top level of the line viewport clipper: config registers, round chain, output register.
//
//  channel | ports                               | payload
//  --------+-------------------------------------+-------------------------------------
//  in      | in_tvalid/in_tready/in_tdata        | segment endpoints
//  out     | out_tvalid/out_tready/out_tdata/tuser| clipped endpoints, accepted flag
//  cfg     | cfg_we/cfg_addr/cfg_wdata           | enable and rectangle edges
//
// Unless the output stalls, one segment enters per cycle. Stages: one code stage, four clip
// rounds of eight each (16-bit edge fraction: four divider stages), one output stage.
// Synchronous active-low reset empties the pipeline and clears all config registers.
// A stall on the output freezes every stage at once; nothing is dropped or repeated.
`default_nettype none
module line_viewport_clipper (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  wire logic [lvc_pkg::DATA_BITS-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // clipped_start_x, clipped_start_y, clipped_start_z, clipped_end_x, clipped_end_y,
  // clipped_end_z
  output logic [lvc_pkg::DATA_BITS-1:0]         out_tdata,
  // accepted
  output logic                                  out_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [lvc_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire logic [lvc_pkg::COORD_BITS-1:0]   cfg_wdata
);
  import lvc_pkg::*;

  logic    clip_en_r;
  bounds_t bnd_r;
  logic    pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_en_r <= 1'b0;
      bnd_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CLIP_ENABLE: clip_en_r   <= cfg_wdata[0];
        REG_MIN_X:       bnd_r.min_x <= cfg_wdata;
        REG_MAX_X:       bnd_r.max_x <= cfg_wdata;
        REG_MIN_Y:       bnd_r.min_y <= cfg_wdata;
        REG_MAX_Y:       bnd_r.max_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic out_tvalid_r;
  assign pipe_en   = !out_tvalid_r || out_tready;
  assign in_tready = pipe_en;

  // code stage: with clipping off, clear the codes so no round moves anything
  seg_t in_seg_c;
  logic in_v_r;
  seg_t in_seg_r;

  always_comb begin
    in_seg_c.p = in_tdata;
    if (clip_en_r) begin
      in_seg_c.code[0] = outcode(coord_t'(in_tdata[0*COORD_BITS +: COORD_BITS]),
                                 coord_t'(in_tdata[1*COORD_BITS +: COORD_BITS]), bnd_r);
      in_seg_c.code[1] = outcode(coord_t'(in_tdata[3*COORD_BITS +: COORD_BITS]),
                                 coord_t'(in_tdata[4*COORD_BITS +: COORD_BITS]), bnd_r);
    end else begin
      in_seg_c.code = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (pipe_en) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      in_seg_r <= in_seg_c;
    end
  end

  logic                        rv  [MAX_CLIP_ROUNDS+1];
  seg_t                        rseg[MAX_CLIP_ROUNDS+1];
  logic [MAX_CLIP_ROUNDS-1:0]  rv_vec;

  assign rv[0]   = in_v_r;
  assign rseg[0] = in_seg_r;

  for (genvar r = 0; r < MAX_CLIP_ROUNDS; r++) begin : g_round
    lvc_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (pipe_en),
      .bnd     (bnd_r),
      .in_v    (rv[r]),
      .in_seg  (rseg[r]),
      .out_v   (rv[r+1]),
      .out_seg (rseg[r+1])
    );
    assign rv_vec[r] = rv[r+1];
  end

  // output stage: drop endpoints of a rejected segment
  seg_t                  fin_seg;
  logic                  ok_c;
  logic [DATA_BITS-1:0]  out_tdata_r;
  logic                  out_tuser_r;

  assign fin_seg = rseg[MAX_CLIP_ROUNDS];
  assign ok_c    = (fin_seg.code[0] | fin_seg.code[1]) == OC_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (pipe_en) begin
      out_tvalid_r <= rv[MAX_CLIP_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_tuser_r <= ok_c;
      out_tdata_r <= ok_c ? fin_seg.p : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("rejected segment carries endpoint data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(rv_vec) && $stable(in_v_r))
    else $error("pipeline moved during stall");

  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && clip_en_r &&
    ($signed(bnd_r.min_x) <= $signed(bnd_r.max_x)) &&
    ($signed(bnd_r.min_y) <= $signed(bnd_r.max_y)) |->
      ($signed(out_tdata[0*COORD_BITS +: COORD_BITS]) >= $signed(bnd_r.min_x)) &&
      ($signed(out_tdata[0*COORD_BITS +: COORD_BITS]) <= $signed(bnd_r.max_x)) &&
      ($signed(out_tdata[1*COORD_BITS +: COORD_BITS]) >= $signed(bnd_r.min_y)) &&
      ($signed(out_tdata[1*COORD_BITS +: COORD_BITS]) <= $signed(bnd_r.max_y)) &&
      ($signed(out_tdata[3*COORD_BITS +: COORD_BITS]) >= $signed(bnd_r.min_x)) &&
      ($signed(out_tdata[3*COORD_BITS +: COORD_BITS]) <= $signed(bnd_r.max_x)) &&
      ($signed(out_tdata[4*COORD_BITS +: COORD_BITS]) >= $signed(bnd_r.min_y)) &&
      ($signed(out_tdata[4*COORD_BITS +: COORD_BITS]) <= $signed(bnd_r.max_y)))
    else $error("accepted endpoint outside the rectangle");

endmodule
`default_nettype wire
